### rtl/assert_macros.svh
// Assertion macros used by the verification checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("Clocked port check failed.");

// Clocked check that also covers the reset cycles.
`define ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("Reset port check failed.");

`endif

### rtl/msq_pkg.sv
// Shared types and constants of the minimum square sum decomposer.
package msq_pkg;

  localparam int MAX_VALUE   = 4095;
  localparam int VALUE_W     = 12;
  localparam int ROOT_W      = 6;
  localparam int CNT_W       = 3;
  localparam int POS_W       = 2;
  localparam int SQ_W        = 13;
  localparam int J_W         = 7;
  localparam int MAX_TERMS   = 4;
  localparam int TABLE_DEPTH = MAX_VALUE + 1;
  localparam int ENTRY_W     = CNT_W + ROOT_W;

  localparam logic [CNT_W-1:0] START_COUNT = CNT_W'(5);
  localparam logic [CNT_W-1:0] TWO_TERMS   = CNT_W'(2);
  localparam logic [CNT_W-1:0] ONE_TERM    = CNT_W'(1);
  localparam logic [CNT_W-1:0] TERM_LIMIT  = CNT_W'(MAX_TERMS);

  typedef logic [MAX_TERMS-1:0][ROOT_W-1:0] root_vec_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] count;
  } core_stat_t;

endpackage

### rtl/msq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module msq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/msq_core.sv
// Table fill and trace-back sequencer sharing one table RAM.
module msq_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [msq_pkg::VALUE_W-1:0]         n_in,
  output msq_pkg::core_stat_t                 stat,
  output msq_pkg::root_vec_t                  roots
);

  typedef enum logic [2:0] {
    C_IDLE,
    C_ITEM,
    C_SEARCH,
    C_TK,
    C_TK2,
    C_TR_RD,
    C_TR_DAT
  } c_state_t;

  c_state_t                        state_r, state_nxt;
  logic [msq_pkg::VALUE_W-1:0]     n_r, n_nxt;
  logic [msq_pkg::VALUE_W-1:0]     i_r, i_nxt;
  logic [msq_pkg::ROOT_W-1:0]      r_r, r_nxt;
  logic [msq_pkg::SQ_W-1:0]        nsq_r, nsq_nxt;
  logic [msq_pkg::J_W-1:0]         j_r, j_nxt;
  logic [msq_pkg::SQ_W-1:0]        sq_r, sq_nxt;
  logic [msq_pkg::CNT_W-1:0]       best_r, best_nxt;
  logic [msq_pkg::ROOT_W-1:0]      root_r, root_nxt;
  logic                            pend_r, pend_nxt;
  logic [msq_pkg::ROOT_W-1:0]      pj_r, pj_nxt;
  logic [msq_pkg::VALUE_W-1:0]     cur_r, cur_nxt;
  logic [msq_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic [msq_pkg::CNT_W-1:0]       k_r, k_nxt;
  msq_pkg::root_vec_t              roots_r, roots_nxt;
  logic                            done_r, done_nxt;

  logic                            we;
  logic [msq_pkg::VALUE_W-1:0]     waddr;
  logic [msq_pkg::ENTRY_W-1:0]     wdata;
  logic [msq_pkg::VALUE_W-1:0]     raddr;
  logic [msq_pkg::ENTRY_W-1:0]     rdata;
  logic [msq_pkg::CNT_W-1:0]       rd_cnt;
  logic [msq_pkg::ROOT_W-1:0]      rd_root;

  logic                            issue;
  logic                            better;
  logic                            finish;
  logic [msq_pkg::CNT_W:0]         cnt_p1;
  logic [msq_pkg::CNT_W-1:0]       k_lim;
  logic [msq_pkg::ROOT_W-1:0]      jv;
  logic [msq_pkg::VALUE_W-1:0]     sqv;

  msq_ram #(
    .WIDTH (msq_pkg::ENTRY_W),
    .DEPTH (msq_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_cnt  = rdata[msq_pkg::ENTRY_W-1:msq_pkg::ROOT_W];
  assign rd_root = rdata[msq_pkg::ROOT_W-1:0];

  assign issue  = (sq_r <= {1'b0, i_r}) && (best_r != msq_pkg::TWO_TERMS);
  assign cnt_p1 = {1'b0, rd_cnt} + (msq_pkg::CNT_W+1)'(1);
  assign better = pend_r && (best_r != msq_pkg::TWO_TERMS) && (cnt_p1 < {1'b0, best_r});
  assign finish = !issue && (!pend_r || (best_r == msq_pkg::TWO_TERMS));
  assign k_lim  = (rd_cnt > msq_pkg::TERM_LIMIT) ? msq_pkg::TERM_LIMIT : rd_cnt;
  assign jv     = (cur_r != '0) ? rd_root : '0;
  assign sqv    = msq_pkg::VALUE_W'(jv) * msq_pkg::VALUE_W'(jv);

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    r_nxt     = r_r;
    nsq_nxt   = nsq_r;
    j_nxt     = j_r;
    sq_nxt    = sq_r;
    best_nxt  = best_r;
    root_nxt  = root_r;
    pend_nxt  = 1'b0;
    pj_nxt    = pj_r;
    cur_nxt   = cur_r;
    pos_nxt   = pos_r;
    k_nxt     = k_r;
    roots_nxt = roots_r;
    done_nxt  = 1'b0;
    we        = 1'b0;
    waddr     = i_r;
    wdata     = '0;
    raddr     = i_r - sq_r[msq_pkg::VALUE_W-1:0];

    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          n_nxt     = n_in;
          i_nxt     = msq_pkg::VALUE_W'(1);
          r_nxt     = msq_pkg::ROOT_W'(1);
          nsq_nxt   = msq_pkg::SQ_W'(4);
          state_nxt = C_ITEM;
        end
      end
      C_ITEM: begin
        if (i_r == msq_pkg::VALUE_W'(1)) begin
          we    = 1'b1;
          wdata = {msq_pkg::ONE_TERM, msq_pkg::ROOT_W'(1)};
        end else if (i_r == msq_pkg::VALUE_W'(2)) begin
          we    = 1'b1;
          wdata = {msq_pkg::TWO_TERMS, msq_pkg::ROOT_W'(1)};
        end else if ({1'b0, i_r} == nsq_r) begin
          we      = 1'b1;
          wdata   = {msq_pkg::ONE_TERM, r_r + msq_pkg::ROOT_W'(1)};
          r_nxt   = r_r + msq_pkg::ROOT_W'(1);
          nsq_nxt = nsq_r + {(msq_pkg::SQ_W-1)'(r_r), 1'b0} + msq_pkg::SQ_W'(3);
        end
        if (we) begin
          if (i_r == n_r) begin
            state_nxt = C_TK;
          end else begin
            i_nxt = i_r + msq_pkg::VALUE_W'(1);
          end
        end else begin
          j_nxt     = msq_pkg::J_W'(1);
          sq_nxt    = msq_pkg::SQ_W'(1);
          best_nxt  = msq_pkg::START_COUNT;
          root_nxt  = '0;
          state_nxt = C_SEARCH;
        end
      end
      C_SEARCH: begin
        if (finish) begin
          we    = 1'b1;
          wdata = {best_r, root_r};
          if (i_r == n_r) begin
            state_nxt = C_TK;
          end else begin
            i_nxt     = i_r + msq_pkg::VALUE_W'(1);
            state_nxt = C_ITEM;
          end
        end else begin
          j_nxt    = j_r + msq_pkg::J_W'(1);
          sq_nxt   = sq_r + {(msq_pkg::SQ_W-1)'(j_r), 1'b0} + msq_pkg::SQ_W'(1);
          pend_nxt = issue;
          pj_nxt   = j_r[msq_pkg::ROOT_W-1:0];
          if (better) begin
            best_nxt = cnt_p1[msq_pkg::CNT_W-1:0];
            root_nxt = pj_r;
          end
        end
      end
      C_TK: begin
        raddr     = n_r;
        state_nxt = C_TK2;
      end
      C_TK2: begin
        k_nxt = k_lim;
        if (k_lim == '0) begin
          done_nxt  = 1'b1;
          state_nxt = C_IDLE;
        end else begin
          cur_nxt   = n_r;
          pos_nxt   = msq_pkg::POS_W'(k_lim - msq_pkg::CNT_W'(1));
          state_nxt = C_TR_RD;
        end
      end
      C_TR_RD: begin
        raddr     = cur_r;
        state_nxt = C_TR_DAT;
      end
      C_TR_DAT: begin
        roots_nxt[pos_r] = jv;
        cur_nxt          = (sqv <= cur_r) ? cur_r - sqv : '0;
        if (pos_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = C_IDLE;
        end else begin
          pos_nxt   = pos_r - msq_pkg::POS_W'(1);
          state_nxt = C_TR_RD;
        end
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      pend_r  <= 1'b0;
      done_r  <= 1'b0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      done_r  <= done_nxt;
      k_r     <= k_nxt;
    end
    n_r     <= n_nxt;
    i_r     <= i_nxt;
    r_r     <= r_nxt;
    nsq_r   <= nsq_nxt;
    j_r     <= j_nxt;
    sq_r    <= sq_nxt;
    best_r  <= best_nxt;
    root_r  <= root_nxt;
    pj_r    <= pj_nxt;
    cur_r   <= cur_nxt;
    pos_r   <= pos_nxt;
    roots_r <= roots_nxt;
  end

  assign stat.done  = done_r;
  assign stat.count = k_r;
  assign roots      = roots_r;

endmodule

### rtl/min_square_sum_decomposer.sv
// Top level of the minimum square sum decomposer with request handshake and result register.
// For a request n the block fills a term-count table for every value from 1 to n and then
// traces back through it, giving one result per square root, the deepest term first and the
// root chosen for n last. The block takes no new request while the table is being built. The
// fill writes each perfect square and 1 and 2 directly and searches every other value over its
// candidate roots; the candidates come to at most about (2/3) * n^1.5, and fewer in practice
// because a search ends as soon as two terms are found. The fill time is set by the single
// table read port, which serves one candidate root per cycle. A request of zero gives no
// result. The next request is taken once the last result of the previous one has entered the
// output register.
module min_square_sum_decomposer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [msq_pkg::VALUE_W-1:0]       in_target_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [msq_pkg::ROOT_W-1:0]        out_term_root,
  output logic [msq_pkg::POS_W-1:0]         out_term_position,
  output logic                              out_is_last
);

  typedef enum logic [1:0] {
    T_IDLE,
    T_BUSY,
    T_EMIT
  } t_state_t;

  t_state_t                        state_r, state_nxt;
  logic [msq_pkg::POS_W-1:0]       e_r, e_nxt;
  logic [msq_pkg::CNT_W-1:0]       k_r, k_nxt;
  logic                            ov_r, ov_nxt;
  logic [msq_pkg::ROOT_W-1:0]      root_r, root_nxt;
  logic [msq_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic                            last_r, last_nxt;

  logic                            start;
  logic                            out_free;
  logic                            is_last;
  msq_pkg::core_stat_t             stat;
  msq_pkg::root_vec_t              roots;

  msq_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .n_in  (in_target_value),
    .stat  (stat),
    .roots (roots)
  );

  assign in_stall = (state_r != T_IDLE);
  assign out_free = !ov_r || !out_stall;
  assign is_last  = ({1'b0, e_r} + msq_pkg::CNT_W'(1)) == k_r;

  always_comb begin
    state_nxt = state_r;
    e_nxt     = e_r;
    k_nxt     = k_r;
    ov_nxt    = ov_r && out_stall;
    root_nxt  = root_r;
    pos_nxt   = pos_r;
    last_nxt  = last_r;
    start     = 1'b0;

    unique case (state_r)
      T_IDLE: begin
        if (in_valid && (in_target_value != '0)) begin
          start     = 1'b1;
          state_nxt = T_BUSY;
        end
      end
      T_BUSY: begin
        if (stat.done) begin
          k_nxt     = stat.count;
          e_nxt     = '0;
          state_nxt = (stat.count == '0) ? T_IDLE : T_EMIT;
        end
      end
      T_EMIT: begin
        if (out_free) begin
          ov_nxt   = 1'b1;
          root_nxt = roots[e_r];
          pos_nxt  = e_r;
          last_nxt = is_last;
          if (is_last) begin
            state_nxt = T_IDLE;
          end else begin
            e_nxt = e_r + msq_pkg::POS_W'(1);
          end
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      ov_r    <= 1'b0;
      e_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      e_r     <= e_nxt;
      k_r     <= k_nxt;
    end
    root_r <= root_nxt;
    pos_r  <= pos_nxt;
    last_r <= last_nxt;
  end

  assign out_valid         = ov_r;
  assign out_term_root     = root_r;
  assign out_term_position = pos_r;
  assign out_is_last       = last_r;

endmodule

### rtl/msq_checker.sv
// Port-level assertion checker for the decomposer and its bind statement.
`include "assert_macros.svh"

module msq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [msq_pkg::VALUE_W-1:0]       in_target_value,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [msq_pkg::ROOT_W-1:0]        out_term_root,
  input logic [msq_pkg::POS_W-1:0]         out_term_position,
  input logic                              out_is_last
);

  logic [msq_pkg::ROOT_W+msq_pkg::POS_W:0] out_word;

  assign out_word = {out_term_root, out_term_position, out_is_last};

  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_word))
  `ASSERT_CLK(a_fourth_is_last, out_valid && (out_term_position == 2'd3) |-> out_is_last)
  `ASSERT_CLK(a_busy_after_req, in_valid && !in_stall && (in_target_value != '0) |=> in_stall)
  `ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_valid)

endmodule

bind min_square_sum_decomposer msq_checker u_msq_checker (.*);

### test/min_square_sum_decomposer_test.sv
// Self-checking testbench of the minimum square sum decomposer with its own predictor.
module min_square_sum_decomposer_test;
  import msq_pkg::*;

  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD     = 500;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [POS_W-1:0]  position;
    logic              is_last;
  } term_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [VALUE_W-1:0] in_target_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ROOT_W-1:0]  out_term_root;
  logic [POS_W-1:0]   out_term_position;
  logic               out_is_last;

  logic [CNT_W-1:0]  fewest_terms [0:MAX_VALUE];
  logic [ROOT_W-1:0] closing_root [0:MAX_VALUE];
  int unsigned       table_top = 0;

  term_t       expected_terms [$];
  term_t       oldest_term;
  int          error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned requests_sent = 0;
  int unsigned zero_requests = 0;
  int unsigned largest_request = 0;
  int unsigned terms_checked = 0;
  bit          idle_on = 1'b1;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned stall_left = 0;

  min_square_sum_decomposer DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_target_value   (in_target_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_term_root     (out_term_root),
    .out_term_position (out_term_position),
    .out_is_last       (out_is_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d terms still expected", $time, expected_terms.size());
      $display("min_square_sum_decomposer_test: errors");
      $finish;
    end
  end

  // Rows only depend on smaller rows, so the table is extended on demand.
  function automatic void extend_tables(int unsigned n);
    int unsigned i, j, r, best, root, prev;
    r = 1;
    for (i = table_top + 1; i <= n; i++) begin
      while ((r + 1) * (r + 1) <= i) r++;
      if (i == 1) begin
        fewest_terms[i] = ONE_TERM;
        closing_root[i] = ROOT_W'(1);
      end else if (i == 2) begin
        fewest_terms[i] = TWO_TERMS;
        closing_root[i] = ROOT_W'(1);
      end else if (r * r == i) begin
        fewest_terms[i] = ONE_TERM;
        closing_root[i] = ROOT_W'(r);
      end else begin
        best = START_COUNT;
        root = 0;
        for (j = 1; j * j <= i; j++) begin
          prev = i - j * j;
          if (best == TWO_TERMS) break;
          if (prev == 0) continue;
          if (best > fewest_terms[prev] + 1) begin
            best = fewest_terms[prev] + 1;
            root = j;
          end
        end
        fewest_terms[i] = CNT_W'(best);
        closing_root[i] = ROOT_W'(root);
      end
    end
    if (n > table_top) table_top = n;
  endfunction

  function automatic void predict_decomposition(logic [VALUE_W-1:0] value);
    int unsigned       n, k, cur, pos, j;
    logic [ROOT_W-1:0] roots [MAX_TERMS];
    term_t             t;
    n = value;
    if (n == 0 || n > MAX_VALUE) return;
    extend_tables(n);
    k = fewest_terms[n];
    if (k > MAX_TERMS) k = MAX_TERMS;
    if (k == 0) return;
    cur = n;
    for (pos = k; pos > 0; pos--) begin
      j = (cur >= 1 && cur <= MAX_VALUE) ? closing_root[cur] : 0;
      roots[pos - 1] = ROOT_W'(j);
      if (j * j <= cur) cur = cur - j * j;
      else cur = 0;
    end
    for (pos = 0; pos < k; pos++) begin
      t.root     = roots[pos];
      t.position = POS_W'(pos);
      t.is_last  = (pos + 1 == k);
      expected_terms = {expected_terms, t};
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_target();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return '0;
    if (r < 84) return VALUE_W'($urandom_range(1, 255));
    if (r < 99) return VALUE_W'($urandom_range(256, 1023));
    return VALUE_W'($urandom_range(1024, MAX_VALUE));
  endfunction

  task automatic offer_request(input logic [VALUE_W-1:0] value);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_target_value <= value;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    if (value == 0) zero_requests++;
    if (value > largest_request) largest_request = value;
    predict_decomposition(value);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_terms.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (hold_requests != holds_served) begin
        stall_left = LONG_HOLD;
        holds_served = hold_requests;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (idle_on && $urandom_range(0, 3) == 0)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      terms_checked++;
      if (expected_terms.size() == 0) begin
        $display("%0t: unexpected term, expected none, actual root %0d position %0d last %0d",
                 $time, out_term_root, out_term_position, out_is_last);
        error_count++;
      end else begin
        oldest_term = expected_terms.pop_front();
        if (out_term_root !== oldest_term.root) begin
          $display("%0t: term_root expected %0d actual %0d", $time, oldest_term.root,
                   out_term_root);
          error_count++;
        end
        if (out_term_position !== oldest_term.position) begin
          $display("%0t: term_position expected %0d actual %0d", $time,
                   oldest_term.position, out_term_position);
          error_count++;
        end
        if (out_is_last !== oldest_term.is_last) begin
          $display("%0t: is_last expected %0d actual %0d", $time, oldest_term.is_last,
                   out_is_last);
          error_count++;
        end
      end
    end
  end

  task automatic test_small_values();
    offer_request(VALUE_W'(1));
    offer_request(VALUE_W'(2));
    offer_request(VALUE_W'(3));
    offer_request(VALUE_W'(4));
    offer_request(VALUE_W'(5));
    offer_request(VALUE_W'(6));
    offer_request(VALUE_W'(7));
    offer_request(VALUE_W'(8));
    offer_request(VALUE_W'(12));
    offer_request(VALUE_W'(15));
    wait_idle();
  endtask

  // A zero request yields no terms and must not disturb its neighbors.
  task automatic test_zero_request();
    offer_request('0);
    offer_request('0);
    offer_request(VALUE_W'(23));
    offer_request('0);
    offer_request(VALUE_W'(1));
    wait_idle();
  endtask

  task automatic test_perfect_squares();
    offer_request(VALUE_W'(9));
    offer_request(VALUE_W'(16));
    offer_request(VALUE_W'(25));
    offer_request(VALUE_W'(3969));
    wait_idle();
  endtask

  task automatic test_largest_value();
    offer_request(VALUE_W'(MAX_VALUE));
    wait_idle();
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (15) offer_request(VALUE_W'($urandom_range(1, 200)));
    wait_idle();
    idle_on = 1'b1;
  endtask

  // The output is held off long enough for the block to back up into its request side.
  task automatic test_output_hold();
    idle_on = 1'b0;
    hold_requests++;
    repeat (8) offer_request(VALUE_W'($urandom_range(1, 40)));
    wait_idle();
    idle_on = 1'b1;
  endtask

  task automatic test_random_mix();
    int i;
    for (i = 0; i < 70; i++) begin
      idle_on = (i % 25) < 20;
      offer_request(pick_target());
    end
    wait_idle();
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_small_values();
    test_zero_request();
    test_perfect_squares();
    test_largest_value();
    test_back_to_back();
    test_output_hold();
    test_random_mix();
    if (expected_terms.size() != 0) begin
      $display("%0t: %0d expected terms never arrived", $time, expected_terms.size());
      error_count++;
    end
    $display("Sent %0d requests (%0d zero, largest %0d) and checked %0d result terms.",
             requests_sent, zero_requests, largest_request, terms_checked);
    $display("Covered small values, perfect squares, full scale, back-to-back traffic %s",
             "and a long output hold.");
    if (error_count == 0) begin
      $display("min_square_sum_decomposer_test: clean");
    end else begin
      $display("min_square_sum_decomposer_test: errors");
    end
    $finish;
  end

endmodule
